// ----- sv/sha256_pkg.sv -----
`default_nettype none
package sha256_pkg;

  typedef enum logic [1:0] {
    SRC_IN,
    SRC_PEND,
    SRC_PAD,
    SRC_LEN
  } src_e;

  typedef struct packed {
    logic       push;
    src_e       src;
    logic       load;
    logic       round;
    logic [5:0] rnd;
    logic       ext;
    logic       fin;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic pad_pending;
  } status_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LengthPos = 6'd56;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

// ----- sv/sha256_ctrl.sv -----
`default_nettype none
module sha256_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire                  last_word_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  sha256_pkg::status_t  status_i,
  output sha256_pkg::cmd_t     cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PEND  = 3'd1;
  localparam logic [2:0] ST_PAD   = 3'd2;
  localparam logic [2:0] ST_LEN   = 3'd3;
  localparam logic [2:0] ST_LOAD  = 3'd4;
  localparam logic [2:0] ST_ROUND = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  localparam logic [1:0] PH_DATA = 2'd0;
  localparam logic [1:0] PH_PAD  = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;

  logic [2:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic [5:0] rnd_q, rnd_d;
  logic       last_q, last_d;
  logic       out_valid_q, out_valid_d;
  sha256_pkg::cmd_t cmd;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    rnd_d      = rnd_q;
    last_d     = last_q;
    in_ready_o = 1'b0;
    cmd        = '0;
    cmd.src    = sha256_pkg::SRC_IN;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd.push = 1'b1;
          last_d   = last_word_i;
          if (status_i.full) begin
            phase_d = PH_DATA;
            state_d = ST_LOAD;
          end else if (last_word_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PEND: begin
        cmd.push = 1'b1;
        cmd.src  = sha256_pkg::SRC_PEND;
        state_d  = last_q ? ST_PAD : ST_IDLE;
      end
      ST_PAD: begin
        if (!status_i.pad_pending) begin
          state_d = ST_LEN;
        end else begin
          cmd.push = 1'b1;
          cmd.src  = sha256_pkg::SRC_PAD;
          if (status_i.full) begin
            phase_d = PH_PAD;
            state_d = ST_LOAD;
          end
        end
      end
      ST_LEN: begin
        cmd.push = 1'b1;
        cmd.src  = sha256_pkg::SRC_LEN;
        if (status_i.full) begin
          phase_d = PH_LEN;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        rnd_d    = '0;
        state_d  = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cmd.rnd   = rnd_q;
        cmd.ext   = rnd_q[5] | rnd_q[4];
        rnd_d     = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.fin = 1'b1;
        priority case (phase_q)
          PH_PAD:  state_d = ST_PAD;
          PH_LEN:  state_d = ST_DONE;
          default: state_d = ST_PEND;
        endcase
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.emit = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_DATA;
      rnd_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      rnd_q       <= rnd_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign out_valid_o = out_valid_q;

  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && rnd_q == 6'd63) |=> state_q == ST_FIN)
    else $error("compression did not finish after the last round");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_q || out_ready_i))
    else $error("digest overwrote an untaken result");

  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd.emit))
    else $error("result valid without a digest");

  a_load_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> $past(status_i.full && cmd.push))
    else $error("compression started on a partial block");

endmodule
`default_nettype wire

// ----- sv/sha256_dp.sv -----
`default_nettype none
module sha256_dp (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire  [31:0]          data_word_i,
  input  wire  [2:0]           valid_bytes_i,
  input  sha256_pkg::cmd_t     cmd_i,
  output sha256_pkg::status_t  status_o,
  output logic [63:0]          digest_part0_o,
  output logic [63:0]          digest_part1_o,
  output logic [63:0]          digest_part2_o,
  output logic [63:0]          digest_part3_o
);

  logic [5:0]   fill_q, fill_d;
  logic [63:0]  bits_q, bits_d;
  logic         pad_first_q, pad_first_d;
  logic [31:0]  hash_q [8];
  logic [31:0]  hash_d [8];
  logic [511:0] blk_q, blk_d;
  logic [31:0]  v_q [8];
  logic [31:0]  v_d [8];
  logic [31:0]  pend_word_q, pend_word_d;
  logic [2:0]   pend_cnt_q, pend_cnt_d;
  logic [63:0]  dig_q [4];
  logic [63:0]  dig_d [4];

  logic [2:0]  n_in;
  logic [6:0]  space;
  logic [5:0]  to_len;
  logic [2:0]  pad_cnt;
  logic [31:0] src_word;
  logic [2:0]  src_cnt;
  logic [2:0]  k;
  logic [6:0]  fill_sum;
  logic [31:0] w;
  logic [31:0] t1, t2;

  assign n_in   = (valid_bytes_i > 3'd4) ? 3'd4 : valid_bytes_i;
  assign space  = 7'd64 - {1'b0, fill_q};
  assign to_len = sha256_pkg::LengthPos - fill_q;

  always_comb begin
    if (fill_q < sha256_pkg::LengthPos && to_len < 6'd4) begin
      pad_cnt = to_len[2:0];
    end else begin
      pad_cnt = 3'd4;
    end
  end

  always_comb begin
    unique case (cmd_i.src)
      sha256_pkg::SRC_IN: begin
        src_word = data_word_i;
        src_cnt  = n_in;
      end
      sha256_pkg::SRC_PEND: begin
        src_word = pend_word_q;
        src_cnt  = pend_cnt_q;
      end
      sha256_pkg::SRC_PAD: begin
        src_word = pad_first_q ? {sha256_pkg::PadByte, 24'h0} : 32'h0;
        src_cnt  = pad_cnt;
      end
      default: begin
        src_word = fill_q[2] ? bits_q[31:0] : bits_q[63:32];
        src_cnt  = 3'd4;
      end
    endcase
  end

  assign k        = ({4'b0, src_cnt} <= space) ? src_cnt : space[2:0];
  assign fill_sum = {1'b0, fill_q} + {4'b0, k};

  assign status_o.full        = fill_sum[6];
  assign status_o.pad_pending = pad_first_q || (fill_q != sha256_pkg::LengthPos);

  // message schedule taken from the block shift line
  always_comb begin
    if (cmd_i.ext) begin
      w = sha256_pkg::ssig1(blk_q[63:32]) + blk_q[223:192]
        + sha256_pkg::ssig0(blk_q[479:448]) + blk_q[511:480];
    end else begin
      w = blk_q[511:480];
    end
  end

  assign t1 = v_q[7] + sha256_pkg::bsig1(v_q[4])
            + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + sha256_pkg::RoundK[cmd_i.rnd] + w;
  assign t2 = sha256_pkg::bsig0(v_q[0])
            + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_comb begin
    fill_d      = fill_q;
    bits_d      = bits_q;
    pad_first_d = pad_first_q;
    hash_d      = hash_q;
    blk_d       = blk_q;
    v_d         = v_q;
    pend_word_d = pend_word_q;
    pend_cnt_d  = pend_cnt_q;
    dig_d       = dig_q;

    if (cmd_i.push) begin
      fill_d = fill_sum[5:0];
      unique case (k)
        3'd1:    blk_d = {blk_q[503:0], src_word[31:24]};
        3'd2:    blk_d = {blk_q[495:0], src_word[31:16]};
        3'd3:    blk_d = {blk_q[487:0], src_word[31:8]};
        3'd4:    blk_d = {blk_q[479:0], src_word};
        default: blk_d = blk_q;
      endcase
      if (cmd_i.src == sha256_pkg::SRC_IN) begin
        bits_d      = bits_q + {58'b0, n_in, 3'b000};
        pend_word_d = data_word_i << {k, 3'b000};
        pend_cnt_d  = n_in - k;
        pad_first_d = 1'b1;
      end
      if (cmd_i.src == sha256_pkg::SRC_PAD) begin
        pad_first_d = 1'b0;
      end
    end

    if (cmd_i.load) begin
      v_d = hash_q;
    end

    if (cmd_i.round) begin
      blk_d  = {blk_q[479:0], w};
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end

    if (cmd_i.fin) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = hash_q[i] + v_q[i];
      end
    end

    if (cmd_i.emit) begin
      for (int i = 0; i < 4; i++) begin
        dig_d[i] = {hash_q[2 * i], hash_q[2 * i + 1]};
      end
      hash_d = sha256_pkg::InitHash;
      fill_d = '0;
      bits_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      bits_q      <= '0;
      pad_first_q <= 1'b0;
      hash_q      <= sha256_pkg::InitHash;
    end else begin
      fill_q      <= fill_d;
      bits_q      <= bits_d;
      pad_first_q <= pad_first_d;
      hash_q      <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q       <= blk_d;
    v_q         <= v_d;
    pend_word_q <= pend_word_d;
    pend_cnt_q  <= pend_cnt_d;
    dig_q       <= dig_d;
  end

  assign digest_part0_o = dig_q[0];
  assign digest_part1_o = dig_q[1];
  assign digest_part2_o = dig_q[2];
  assign digest_part3_o = dig_q[3];

endmodule
`default_nettype wire

// ----- sv/sha256_stream_hasher_top.sv -----
// SHA-256 over a stream of big-endian 32-bit words (first byte in bits 31..24,
// valid_bytes_i of them used, counts above four taken as four). A word marked
// last_word_i closes the message: the block pads it, hashes the final block or
// two and offers the 256-bit digest as four 64-bit parts, then starts a new
// message. Every completed 64-byte block goes through the single shared round
// unit (load, 64 rounds, chaining add), during which no request is accepted,
// and a block completed by a request is followed by a step that takes in the
// bytes of that request left over. Padding is pushed up to four bytes at a
// time, a step without a push hands over to the length, which is pushed as two
// 32-bit words, and the digest register is loaded after the last compression
// once the previous result is taken.
`default_nettype none
module sha256_stream_hasher_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [31:0] data_word_i,
  input  wire  [2:0]  valid_bytes_i,
  input  wire         last_word_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [63:0] digest_part0_o,
  output logic [63:0] digest_part1_o,
  output logic [63:0] digest_part2_o,
  output logic [63:0] digest_part3_o
);

  sha256_pkg::cmd_t    cmd;
  sha256_pkg::status_t status;

  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .last_word_i (last_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sha256_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_word_i    (data_word_i),
    .valid_bytes_i  (valid_bytes_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .digest_part0_o (digest_part0_o),
    .digest_part1_o (digest_part1_o),
    .digest_part2_o (digest_part2_o),
    .digest_part3_o (digest_part3_o)
  );

endmodule
`default_nettype wire
